>>> rtl/bone_hierarchy_compose_top_assert.svh
// assertion macros shared by the bone hierarchy compose rtl
`ifndef BONE_HIERARCHY_COMPOSE_TOP_ASSERT_SVH
`define BONE_HIERARCHY_COMPOSE_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define BHC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define BHC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bhc_pkg.sv
// types and constants of the bone hierarchy compose block
package bhc_pkg;

   // skeleton size and fixed-point format
   localparam int MAX_BONES = 64;
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int BONE_W = 6;
   localparam int ROW_W  = 2;
   localparam int WORD_W = 32;
   localparam int COLS   = 4;
   localparam int ROWS   = 4;

   // store organised as one 128-bit word per matrix row
   localparam int STORE_ROWS = MAX_BONES * ROWS;
   localparam int ADDR_W     = $clog2(STORE_ROWS);

   // product and accumulator widths
   localparam int PROD_W = 2 * WORD_W;
   localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

   // clamp limits
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  SUM_MAX  = ACC_W'(WORD_MAX);
   localparam logic signed [ACC_W-1:0]  SUM_MIN  = ACC_W'(WORD_MIN);

   localparam logic [ROW_W-1:0] K_FIRST = '0;
   localparam logic [ROW_W-1:0] K_LAST  = ROW_W'(ROWS - 1);

   typedef logic [COLS-1:0][WORD_W-1:0] row_type;

   typedef struct packed {
      logic [BONE_W-1:0]        bone_index;
      logic                     has_parent;
      logic [BONE_W-1:0]        parent_index;
      logic [ROW_W-1:0]         row_index;
      logic signed [WORD_W-1:0] rel_c0;
      logic signed [WORD_W-1:0] rel_c1;
      logic signed [WORD_W-1:0] rel_c2;
      logic signed [WORD_W-1:0] rel_c3;
   } req_word_type;

   typedef struct packed {
      logic [BONE_W-1:0]        out_bone;
      logic [ROW_W-1:0]         out_row;
      logic signed [WORD_W-1:0] abs_c0;
      logic signed [WORD_W-1:0] abs_c1;
      logic signed [WORD_W-1:0] abs_c2;
      logic signed [WORD_W-1:0] abs_c3;
      logic                     order_error;
      logic                     saturated;
   } rsp_word_type;

   // control from the sequencer to the multiply-accumulate lanes
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] k;
   } mac_ctl_type;

endpackage

>>> rtl/bhc_if.sv
// valid/ready channel interfaces for request and response words
interface bhc_req_if;
   import bhc_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface bhc_rsp_if;
   import bhc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> rtl/bone_hierarchy_compose_top.sv
// Bone hierarchy composer: relative bone matrix rows in, absolute rows out.
// req_chan carries one row of a bone's relative 4x4 matrix (Q16.16) with
// the bone index, parent index and a parent flag; rsp_chan returns the
// matching absolute row. Bones must arrive parent first. Valid/ready on
// both channels, a word moves when valid and ready are high at a clock edge.
// A root row passes straight through to the output. A child row reads
// the parent's four absolute rows from the store, one row a cycle through the
// single read port, multiplies them in four lanes and accumulates; the
// result is registered in the accumulators, then loads the output register.
// The next word is taken only once the block is back in idle. A parent index
// not below the bone index flags order_error and passes the row through.
// Every result row is written back to the store for later children.
// Synchronous active-high reset clears control only; the store content is
// undefined until written and needs no clearing pass.
// A stalled receiver holds the result in the output register; the next word
// is still accepted and computed, and waits only to load that register.
`include "bone_hierarchy_compose_top_assert.svh"

module bone_hierarchy_compose_top (
   input logic     clock,
   input logic     reset,
   bhc_req_if.sink   req_chan,
   bhc_rsp_if.source rsp_chan
);
   import bhc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_COMP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   req_word_type item_ff;
   logic         err_ff, err_in;
   logic         calc_ff, calc_in;
   logic [ROW_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic         rd_vld_ff;
   logic [ROW_W-1:0] rd_k_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         req_take;
   logic         out_load;
   logic         mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   row_type      mem_rdata;
   row_type      rel_row, sum_row, res_row;
   logic         sum_sat, mac_done;
   mac_ctl_type  mac_ctl;

   // input handshake
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign err_in  = req_chan.data.has_parent &&
                    (req_chan.data.parent_index >= req_chan.data.bone_index);
   assign calc_in = req_chan.data.has_parent && !err_in;

   // output register free or draining this cycle
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_cnt_in = K_FIRST;
            if (req_take) begin
               state_in = calc_in ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == K_LAST) begin
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= K_FIRST;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         rd_vld_ff <= mem_re;
      end
   end

   // accepted word and its flags
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_chan.data;
         err_ff  <= err_in;
         calc_ff <= calc_in;
      end
      if (mem_re) begin
         rd_k_ff <= rd_cnt_ff;
      end
   end

   // parent row reads, one per cycle
   assign mem_re    = (state_ff == ST_READ);
   assign mem_raddr = ADDR_W'({item_ff.parent_index, rd_cnt_ff});

   // write the result row back when it loads the output register
   assign mem_we    = out_load && (32'(item_ff.bone_index) < MAX_BONES);
   assign mem_waddr = ADDR_W'({item_ff.bone_index, item_ff.row_index});

   bhc_ram #(
      .DEPTH (STORE_ROWS),
      .WIDTH (COLS * WORD_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (res_row),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rel_row = row_type'({item_ff.rel_c3, item_ff.rel_c2,
                               item_ff.rel_c1, item_ff.rel_c0});

   assign mac_ctl.valid = rd_vld_ff;
   assign mac_ctl.k     = rd_k_ff;

   bhc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .rel_row (rel_row),
      .par_row (mem_rdata),
      .sum_row (sum_row),
      .sum_sat (sum_sat),
      .done    (mac_done)
   );

   // result row: composed or passed through
   assign res_row = calc_ff ? sum_row : rel_row;

   always_comb begin
      rsp_in.out_bone    = item_ff.bone_index;
      rsp_in.out_row     = item_ff.row_index;
      rsp_in.abs_c0      = $signed(res_row[0]);
      rsp_in.abs_c1      = $signed(res_row[1]);
      rsp_in.abs_c2      = $signed(res_row[2]);
      rsp_in.abs_c3      = $signed(res_row[3]);
      rsp_in.order_error = err_ff;
      rsp_in.saturated   = calc_ff && sum_sat;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // checks
   `BHC_ASSERT_IMP(a_read_parent_first, clock, reset, state_ff == ST_READ,
      item_ff.parent_index < item_ff.bone_index, "parent read for out-of-order bone")
   `BHC_ASSERT_IMP(a_done_in_comp, clock, reset, mac_done,
      state_ff == ST_COMP, "accumulation finished outside compute phase")
   `BHC_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_ff.order_error && rsp_ff.saturated), "order error with saturation")
   `BHC_ASSERT_IMP(a_no_overwrite, clock, reset, out_load,
      !rsp_valid_ff || rsp_chan.ready, "pending result overwritten")
   `BHC_ASSERT_NXT(a_write_then_idle, clock, reset, mem_we,
      state_ff == ST_IDLE, "store written without returning to idle")
endmodule

>>> rtl/bhc_ram.sv
// single write port, single registered read port ram
module bhc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/bhc_mac.sv
// four-lane multiply-accumulate over the parent rows, with clamping
module bhc_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  bhc_pkg::mac_ctl_type ctl,
   input  bhc_pkg::row_type     rel_row,
   input  bhc_pkg::row_type     par_row,
   output bhc_pkg::row_type     sum_row,
   output logic                 sum_sat,
   output logic                 done
);
   import bhc_pkg::*;

   logic signed [WORD_W-1:0] rel_sel;
   logic signed [PROD_W-1:0] prod_in [COLS];
   logic signed [PROD_W-1:0] prod_ff [COLS];
   logic                     p_vld_in, p_vld_ff;
   logic [ROW_W-1:0]         p_k_ff;
   logic signed [ACC_W-1:0]  acc_in  [COLS];
   logic signed [ACC_W-1:0]  acc_ff  [COLS];
   logic                     done_in, done_ff;
   logic [COLS-1:0]          lane_sat;

   // pick the relative entry that meets this parent row
   assign rel_sel = $signed(rel_row[ctl.k]);

   // one full-width product per column
   always_comb begin
      for (int j = 0; j < COLS; j++) begin
         prod_in[j] = rel_sel * $signed(par_row[j]);
      end
   end

   assign p_vld_in = ctl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= p_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         p_k_ff <= ctl.k;
         for (int j = 0; j < COLS; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
   end

   // floor shift and accumulate, restarting on the first row
   always_comb begin
      for (int j = 0; j < COLS; j++) begin
         acc_in[j] = ((p_k_ff == K_FIRST) ? '0 : acc_ff[j])
                   + ACC_W'(prod_ff[j] >>> FRAC_BITS);
      end
   end

   assign done_in = p_vld_ff && (p_k_ff == K_LAST);

   always_ff @(posedge clock) begin
      if (p_vld_ff) begin
         for (int j = 0; j < COLS; j++) begin
            acc_ff[j] <= acc_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   // clamp each column to the word range
   always_comb begin
      for (int j = 0; j < COLS; j++) begin
         lane_sat[j] = 1'b1;
         if (acc_ff[j] > SUM_MAX) begin
            sum_row[j] = WORD_MAX;
         end else if (acc_ff[j] < SUM_MIN) begin
            sum_row[j] = WORD_MIN;
         end else begin
            sum_row[j]  = acc_ff[j][WORD_W-1:0];
            lane_sat[j] = 1'b0;
         end
      end
   end

   assign sum_sat = |lane_sat;
   assign done    = done_ff;
endmodule

>>> dv/tb_bone_hierarchy_compose_top.sv
// testbench for the bone hierarchy composer: skeleton row stimulus, row predictor, checks
`timescale 1ns / 1ps

module tb_bone_hierarchy_compose_top;
   import bhc_pkg::*;

   localparam logic [WORD_W-1:0] Q_ONE = 32'h1 << FRAC_BITS;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_AFTER = 150;
   localparam int unsigned TARGET_ROWS = 520;

   typedef enum {ROW_ROOT, ROW_CHILD, ROW_MISORDERED} row_kind_type;
   typedef enum {RX_OPEN, RX_PATCHY, RX_CHOKED} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   bhc_req_if req_chan();
   bhc_rsp_if rsp_chan();

   bone_hierarchy_compose_top DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // clock
   always begin
      #5 clock = ~clock;
   end

   // stimulus side
   req_word_type pending_rows[$];
   bit [ROWS-1:0] rows_seen [MAX_BONES];

   // prediction side
   logic signed [WORD_W-1:0] abs_store [MAX_BONES][ROWS][COLS];
   rsp_word_type expected_rows[$];
   rsp_word_type oldest_row;
   int unsigned rows_accepted = 0;
   int unsigned mismatches = 0;
   bit req_taken = 1'b0;

   // sender and receiver pacing
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   int unsigned phase_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   // absolute row of one relative row, updates the store as the block does
   function automatic rsp_word_type compose_row(req_word_type w);
      rsp_word_type r;
      logic signed [WORD_W-1:0] rel [COLS];
      logic signed [WORD_W-1:0] res [COLS];
      longint acc;
      longint prod;
      bit err;
      bit sat;
      rel[0] = w.rel_c0;
      rel[1] = w.rel_c1;
      rel[2] = w.rel_c2;
      rel[3] = w.rel_c3;
      err = w.has_parent && (w.parent_index >= w.bone_index);
      sat = 1'b0;
      for (int j = 0; j < COLS; j++) begin
         if (w.has_parent && !err) begin
            acc = 0;
            // exact product, floor shift, exact sum
            for (int k = 0; k < ROWS; k++) begin
               prod = longint'(rel[k]) * longint'(abs_store[w.parent_index][k][j]);
               acc += prod >>> FRAC_BITS;
            end
            if (acc > longint'(WORD_MAX)) begin
               acc = longint'(WORD_MAX);
               sat = 1'b1;
            end else if (acc < longint'(WORD_MIN)) begin
               acc = longint'(WORD_MIN);
               sat = 1'b1;
            end
            res[j] = WORD_W'(acc);
         end else begin
            res[j] = rel[j];
         end
      end
      for (int j = 0; j < COLS; j++)
         abs_store[w.bone_index][w.row_index][j] = res[j];
      r.out_bone = w.bone_index;
      r.out_row = w.row_index;
      r.abs_c0 = res[0];
      r.abs_c1 = res[1];
      r.abs_c2 = res[2];
      r.abs_c3 = res[3];
      r.order_error = err;
      r.saturated = sat;
      return r;
   endfunction

   function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   // random matrix entry: mostly small values, some full range, some extremes
   function automatic logic [WORD_W-1:0] pick_entry();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return $urandom_range(0, 2 ** 19) - 2 ** 18;
      if (sel < 8)
         return $urandom();
      case ($urandom_range(0, 5))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         4: return Q_ONE;
         default: return -Q_ONE;
      endcase
   endfunction

   // a parent below the bone whose four rows have all been sent, or -1
   function automatic int pick_parent(int bone);
      int candidates[$];
      for (int p = 0; p < bone; p++)
         if (rows_seen[p] == '1)
            candidates.push_back(p);
      if (candidates.size() == 0)
         return -1;
      return candidates[$urandom_range(0, candidates.size() - 1)];
   endfunction

   task automatic send_row(input logic [BONE_W-1:0] bone, input logic has_parent,
                           input logic [BONE_W-1:0] parent, input logic [ROW_W-1:0] row,
                           input logic [WORD_W-1:0] c0, input logic [WORD_W-1:0] c1,
                           input logic [WORD_W-1:0] c2, input logic [WORD_W-1:0] c3);
      req_word_type w;
      w.bone_index = bone;
      w.has_parent = has_parent;
      w.parent_index = parent;
      w.row_index = row;
      w.rel_c0 = c0;
      w.rel_c1 = c1;
      w.rel_c2 = c2;
      w.rel_c3 = c3;
      pending_rows.push_back(w);
      rows_seen[bone][row] = 1'b1;
   endtask

   // all four rows of one bone, starting at a random row
   task automatic send_bone(input int bone, input logic has_parent, input int parent);
      int unsigned start;
      start = $urandom_range(0, ROWS - 1);
      for (int i = 0; i < ROWS; i++)
         send_row(BONE_W'(bone), has_parent, BONE_W'(parent), ROW_W'(start + i),
                  pick_entry(), pick_entry(), pick_entry(), pick_entry());
   endtask

   // row driver, bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // word still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (pending_rows.size() > 0) begin
         req_chan.data <= pending_rows.pop_front();
         req_chan.valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // receiver stall pattern, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!hold_done && rows_accepted >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 2));
               phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            case (rx_mode)
               RX_OPEN: rsp_chan.ready <= 1'b1;
               RX_PATCHY: rsp_chan.ready <= $urandom_range(0, 1);
               default: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // accepted rows feed the predictor, returned rows are checked in order
   always @(posedge clock) begin
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         expected_rows.push_back(compose_row(req_chan.data));
         rows_accepted++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rows.size() == 0) begin
            $error("result word with no row outstanding: bone %0d row %0d",
                   rsp_chan.data.out_bone, rsp_chan.data.out_row);
            mismatches++;
         end else begin
            oldest_row = expected_rows.pop_front();
            check_field("out_bone", oldest_row.out_bone, rsp_chan.data.out_bone);
            check_field("out_row", oldest_row.out_row, rsp_chan.data.out_row);
            check_field("abs_c0", oldest_row.abs_c0, rsp_chan.data.abs_c0);
            check_field("abs_c1", oldest_row.abs_c1, rsp_chan.data.abs_c1);
            check_field("abs_c2", oldest_row.abs_c2, rsp_chan.data.abs_c2);
            check_field("abs_c3", oldest_row.abs_c3, rsp_chan.data.abs_c3);
            check_field("order_error", oldest_row.order_error, rsp_chan.data.order_error);
            check_field("saturated", oldest_row.saturated, rsp_chan.data.saturated);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int bone;
      int parent;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;

      // identity root, then a root of all-maximum entries
      for (int r = 0; r < ROWS; r++)
         send_row(6'd0, 1'b0, 6'd0, ROW_W'(r), (r == 0) ? Q_ONE : '0,
                  (r == 1) ? Q_ONE : '0, (r == 2) ? Q_ONE : '0, (r == 3) ? Q_ONE : '0);
      for (int r = 0; r < ROWS; r++)
         send_row(6'd2, 1'b0, 6'd0, ROW_W'(r), WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      // children: pass through identity, clamp both ways, floor of negatives
      send_row(6'd1, 1'b1, 6'd0, 2'd0, WORD_MAX, WORD_MIN, '1, '0);
      send_row(6'd1, 1'b1, 6'd0, 2'd3, 32'd1, 32'd2, 32'd3, 32'd4);
      send_row(6'd3, 1'b1, 6'd2, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_row(6'd3, 1'b1, 6'd2, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_row(6'd3, 1'b1, 6'd2, 2'd2, '1, '1, '1, '1);
      send_row(6'd3, 1'b1, 6'd2, 2'd3, Q_ONE, '0, '0, '0);
      // parent equal to or above the bone
      send_row(6'd5, 1'b1, 6'd5, 2'd0, WORD_MIN, WORD_MAX, '0, '1);
      send_row(6'd4, 1'b1, 6'd63, 2'd1, '1, WORD_MIN, WORD_MAX, Q_ONE);
      send_row(6'd63, 1'b1, 6'd63, 2'd2, WORD_MAX, '1, WORD_MIN, '0);
      send_row(6'd0, 1'b1, 6'd0, 2'd1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      // root with a parent field set, which is ignored
      send_row(6'd63, 1'b0, 6'd63, 2'd3, '1, '1, '1, '1);
      // deepest bone index as a child
      send_row(6'd63, 1'b1, 6'd3, 2'd1, Q_ONE, -Q_ONE, WORD_MAX, WORD_MIN);

      // random skeletons: whole bones parent first, plus stray rows
      while (pending_rows.size() < TARGET_ROWS) begin
         bone = $urandom_range(0, MAX_BONES - 1);
         parent = pick_parent(bone);
         if ($urandom_range(0, 99) < 80) begin
            if (parent >= 0 && $urandom_range(0, 9) < 7)
               send_bone(bone, 1'b1, parent);
            else
               send_bone(bone, 1'b0, $urandom_range(0, MAX_BONES - 1));
         end else begin
            case (row_kind_type'($urandom_range(0, 2)))
               ROW_CHILD: begin
                  if (parent >= 0)
                     send_row(BONE_W'(bone), 1'b1, BONE_W'(parent),
                              ROW_W'($urandom_range(0, ROWS - 1)),
                              pick_entry(), pick_entry(), pick_entry(), pick_entry());
               end
               ROW_ROOT: begin
                  send_row(BONE_W'(bone), 1'b0, BONE_W'($urandom_range(0, MAX_BONES - 1)),
                           ROW_W'($urandom_range(0, ROWS - 1)),
                           pick_entry(), pick_entry(), pick_entry(), pick_entry());
               end
               default: begin
                  send_row(BONE_W'(bone), 1'b1, BONE_W'($urandom_range(bone, MAX_BONES - 1)),
                           ROW_W'($urandom_range(0, ROWS - 1)),
                           pick_entry(), pick_entry(), pick_entry(), pick_entry());
               end
            endcase
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: every row sent and every result back
      while (pending_rows.size() != 0 || req_chan.valid || expected_rows.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (expected_rows.size() != 0) begin
         $error("%0d result words never arrived", expected_rows.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> bone_hierarchy_compose_top.f
+incdir+rtl
rtl/bhc_pkg.sv
rtl/bhc_if.sv
rtl/bhc_ram.sv
rtl/bhc_mac.sv
rtl/bone_hierarchy_compose_top.sv
dv/tb_bone_hierarchy_compose_top.sv
